// ===== src/frac_pkg.sv =====
// ----------------------------------------------------------------------------
// Fraction reducer package
// Shared value width, word types and unit status type for the fraction reducer.
// ----------------------------------------------------------------------------
package frac_pkg;

   localparam int VALUE_WIDTH = 32;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] numerator_in;
      logic signed [VALUE_WIDTH-1:0] denominator_in;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] numerator_out;
      logic signed [VALUE_WIDTH-1:0] denominator_out;
      logic        [VALUE_WIDTH-1:0] common_divisor;
      logic                          zero_denominator;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ===== src/frac_gcd.sv =====
// ----------------------------------------------------------------------------
// Binary GCD unit
// Computes the greatest common divisor of two magnitudes, one step a cycle.
// ----------------------------------------------------------------------------
module frac_gcd #(
   parameter int WIDTH = frac_pkg::VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [WIDTH-1:0]       a_in,
   input  logic [WIDTH-1:0]       b_in,
   output frac_pkg::unit_stat_type stat,
   output logic [WIDTH-1:0]       result
);
   import frac_pkg::*;

   localparam int KW = $clog2(WIDTH);

   logic [WIDTH-1:0] a_ff, a_in_nx, b_ff, b_in_nx;
   logic [KW-1:0]    k_ff, k_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH:0]   diff_ab, diff_ba;
   logic             a_gt_b;

   assign diff_ab = {1'b0, a_ff} - {1'b0, b_ff};
   assign diff_ba = {1'b0, b_ff} - {1'b0, a_ff};
   assign a_gt_b  = !diff_ab[WIDTH] && (diff_ab != '0);

   always_comb begin
      a_in_nx = a_ff;
      b_in_nx = b_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         a_in_nx = a_in;
         b_in_nx = b_in;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            res_in  = a_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in_nx = a_ff >> 1;
            b_in_nx = b_ff >> 1;
            k_in    = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in_nx = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in_nx = b_ff >> 1;
         end else if (a_gt_b) begin
            a_in_nx = diff_ab[WIDTH:1];
         end else begin
            b_in_nx = diff_ba[WIDTH:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in_nx;
      b_ff   <= b_in_nx;
      k_ff   <= k_in;
      res_ff <= res_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

// ===== src/frac_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit a cycle, shared by both quotients.
// ----------------------------------------------------------------------------
module frac_div #(
   parameter int WIDTH = frac_pkg::VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [WIDTH-1:0]       dividend,
   input  logic [WIDTH-1:0]       divisor,
   output frac_pkg::unit_stat_type stat,
   output logic [WIDTH-1:0]       quotient
);
   import frac_pkg::*;

   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   logic [WIDTH-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [WIDTH:0]   part, trial;

   assign part  = {rem_ff, quo_ff[WIDTH-1]};
   assign trial = part - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = LAST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = part[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== src/fraction_reducer_top.sv =====
// ----------------------------------------------------------------------------
// Fraction reducer
// Reduces a signed fraction to lowest terms by the GCD of its magnitudes.
// ----------------------------------------------------------------------------
// A word on the request channel carries a signed numerator and denominator.
// The block takes it when req_valid is high and req_stall is low, and
// req_stall stays high until that word's result is in the output register.
// The response word holds both reduced values, each with its own sign, the
// divisor removed and a zero denominator flag. A zero denominator returns
// the inputs unchanged with a divisor of zero. Otherwise a binary GCD
// unit takes one step a cycle, and one restoring divider is then used
// twice, once for each quotient. The result waits in an output register
// while rsp_stall is high, and the next request word may be taken
// meanwhile. Synchronous reset empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
module fraction_reducer_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  frac_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output frac_pkg::rsp_word_type rsp_word
);
   import frac_pkg::*;

   localparam int W = VALUE_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GCD  = 5'b00010,
      ST_DIVN = 5'b00100,
      ST_DIVD = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [W-1:0]  nmag_ff, nmag_in, dmag_ff, dmag_in, g_ff, g_in;
   logic          nneg_ff, nneg_in, dneg_ff, dneg_in;
   rsp_word_type  res_ff, res_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [W-1:0]  req_n, req_d, req_nmag, req_dmag;
   logic          take;
   logic          gcd_start, div_start;
   logic [W-1:0]  gcd_result, div_quotient, div_dividend, div_divisor;
   unit_stat_type gcd_stat, div_stat;

   assign req_n    = req_word.numerator_in;
   assign req_d    = req_word.denominator_in;
   assign req_nmag = req_n[W-1] ? (~req_n + 1'b1) : req_n;
   assign req_dmag = req_d[W-1] ? (~req_d + 1'b1) : req_d;

   assign take      = (state_ff == ST_IDLE) && req_valid;
   assign gcd_start = take && (req_d != '0);
   assign div_start = ((state_ff == ST_GCD) && gcd_stat.done) ||
                      ((state_ff == ST_DIVN) && div_stat.done);

   assign div_dividend = (state_ff == ST_GCD) ? nmag_ff : dmag_ff;
   assign div_divisor  = (state_ff == ST_GCD) ? gcd_result : g_ff;

   frac_gcd #(.WIDTH(W)) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .a_in   (req_dmag),
      .b_in   (req_nmag),
      .stat   (gcd_stat),
      .result (gcd_result)
   );

   frac_div #(.WIDTH(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      nmag_in      = nmag_ff;
      dmag_in      = dmag_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      g_in         = g_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               nmag_in = req_nmag;
               dmag_in = req_dmag;
               nneg_in = req_n[W-1];
               dneg_in = req_d[W-1];
               if (req_d == '0) begin
                  res_in.numerator_out    = req_word.numerator_in;
                  res_in.denominator_out  = req_word.denominator_in;
                  res_in.common_divisor   = '0;
                  res_in.zero_denominator = 1'b1;
                  state_in                = ST_DONE;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (gcd_stat.done) begin
               g_in     = gcd_result;
               state_in = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (div_stat.done) begin
               res_in.numerator_out = nneg_ff ? (~div_quotient + 1'b1) : div_quotient;
               state_in             = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_stat.done) begin
               res_in.denominator_out  = dneg_ff ? (~div_quotient + 1'b1) : div_quotient;
               res_in.common_divisor   = g_ff;
               res_in.zero_denominator = 1'b0;
               state_in                = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      g_ff    <= g_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block did not go busy after taking a request word");

   a_zero_den_divisor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.zero_denominator) |-> (rsp_word.common_divisor == '0))
      else $error("zero denominator result carries a nonzero divisor");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.zero_denominator) |-> (rsp_word.common_divisor != '0))
      else $error("reduced result carries a zero divisor");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(gcd_stat.busy && div_stat.busy))
      else $error("GCD unit and divider busy at once");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fraction reducer testbench
// Feeds signed fractions into the reducer and checks every response word
// against a local model that strips the greatest common divisor of the two
// magnitudes. Directed words cover zero and extreme values; random words
// cover shared factors, small values and full-width patterns, with random
// idle cycles on both channels and stretches without any.
// ----------------------------------------------------------------------------
module tb;
   import frac_pkg::*;

   localparam int W = VALUE_WIDTH;
   localparam logic signed [W-1:0] MOST_NEGATIVE = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] MOST_POSITIVE = {1'b0, {(W-1){1'b1}}};

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   rsp_word_type reduced_fractions_due[$];
   bit           idle_enable = 1'b1;
   int           fractions_accepted = 0;
   int           results_checked = 0;
   int           zero_denominators_seen = 0;
   int           mismatch_count = 0;

   fraction_reducer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("%0t: timed out with %0d results outstanding", $time,
               reduced_fractions_due.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic [W-1:0] gcd_of_magnitudes(logic [W-1:0] a, logic [W-1:0] b);
      logic [W-1:0] t;
      while (b != '0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic rsp_word_type reduce_fraction(req_word_type w);
      rsp_word_type r;
      logic         num_neg;
      logic         den_neg;
      logic [W-1:0] num_mag;
      logic [W-1:0] den_mag;
      logic [W-1:0] g;
      r = '0;
      if (w.denominator_in == '0) begin
         r.numerator_out    = w.numerator_in;
         r.denominator_out  = w.denominator_in;
         r.zero_denominator = 1'b1;
         return r;
      end
      num_neg = w.numerator_in[W-1];
      den_neg = w.denominator_in[W-1];
      num_mag = num_neg ? {W{1'b0}} - $unsigned(w.numerator_in) : $unsigned(w.numerator_in);
      den_mag = den_neg ? {W{1'b0}} - $unsigned(w.denominator_in)
                        : $unsigned(w.denominator_in);
      g = gcd_of_magnitudes(den_mag, num_mag);
      r.numerator_out   = num_neg ? {W{1'b0}} - num_mag / g : num_mag / g;
      r.denominator_out = den_neg ? {W{1'b0}} - den_mag / g : den_mag / g;
      r.common_divisor  = g;
      return r;
   endfunction

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic offer_fraction(logic signed [W-1:0] num, logic signed [W-1:0] den);
      int gap;
      gap = idle_enable ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_word.numerator_in   <= num;
      req_word.denominator_in <= den;
      do @(posedge clock); while (req_stall);
      reduced_fractions_due.push_back(reduce_fraction('{num, den}));
      fractions_accepted++;
   endtask

   function automatic logic signed [W-1:0] with_random_sign(logic [W-1:0] mag);
      return $urandom_range(0, 1) ? {W{1'b0}} - mag : mag;
   endfunction

   task automatic report_field(string name, logic signed [W-1:0] exp_val,
                               logic signed [W-1:0] act_val);
      mismatch_count++;
      $display("%0t: %s expected %0d (%h) got %0d (%h)", $time, name,
               exp_val, exp_val, act_val, act_val);
   endtask

   // Receiver: holds rsp_stall for a drawn number of valid cycles per word.
   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         hold = idle_enable ? $urandom_range(0, 4) : 0;
         rsp_stall <= (hold != 0);
         forever begin
            @(posedge clock);
            if (rsp_valid && !rsp_stall) break;
            if (rsp_valid && hold != 0) begin
               hold--;
               if (hold == 0) rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reduced_fractions_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word %h with nothing expected", $time, rsp_word);
         end else begin
            exp_word = reduced_fractions_due.pop_front();
            results_checked++;
            if (exp_word.zero_denominator) zero_denominators_seen++;
            if (rsp_word.numerator_out !== exp_word.numerator_out)
               report_field("numerator_out", exp_word.numerator_out, rsp_word.numerator_out);
            if (rsp_word.denominator_out !== exp_word.denominator_out)
               report_field("denominator_out", exp_word.denominator_out,
                            rsp_word.denominator_out);
            if (rsp_word.common_divisor !== exp_word.common_divisor)
               report_field("common_divisor", $signed(exp_word.common_divisor),
                            $signed(rsp_word.common_divisor));
            if (rsp_word.zero_denominator !== exp_word.zero_denominator)
               report_field("zero_denominator",
                            {{(W-1){1'b0}}, exp_word.zero_denominator},
                            {{(W-1){1'b0}}, rsp_word.zero_denominator});
         end
      end
   end

   task automatic test_special_values();
      offer_fraction(32'sd7, 32'sd0);
      offer_fraction(32'sd0, 32'sd0);
      offer_fraction(MOST_NEGATIVE, 32'sd0);
      offer_fraction(MOST_POSITIVE, 32'sd0);
      offer_fraction(32'sd0, 32'sd5);
      offer_fraction(32'sd0, -32'sd9);
      offer_fraction(32'sd0, MOST_NEGATIVE);
      offer_fraction(32'sd0, MOST_POSITIVE);
      offer_fraction(MOST_NEGATIVE, MOST_NEGATIVE);
      offer_fraction(MOST_NEGATIVE, -32'sd1);
      offer_fraction(MOST_NEGATIVE, 32'sd2);
      offer_fraction(32'sd1, MOST_NEGATIVE);
      offer_fraction(MOST_POSITIVE, MOST_POSITIVE);
      offer_fraction(MOST_NEGATIVE, MOST_POSITIVE);
      offer_fraction(-32'sd1, -32'sd1);
      offer_fraction(-32'sd6, 32'sd4);
      offer_fraction(32'sd12, -32'sd18);
      offer_fraction(32'sd9, 32'sd3);
      offer_fraction(32'sd13, 32'sd17);
      offer_fraction(32'sh4000_0000, 32'sh2000_0000);
      offer_fraction(32'sd65536, -32'sd98304);
   endtask

   task automatic test_common_factors(int count);
      logic [W-1:0] g;
      logic [W-1:0] a;
      logic [W-1:0] b;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            g = 32'd1 << $urandom_range(0, 30);
            a = $urandom_range(0, 31'h7fff_ffff) >> $urandom_range(0, 30);
            b = $urandom_range(1, 31'h7fff_ffff) >> $urandom_range(0, 30);
            a = (a * g) & MOST_POSITIVE;
            b = (b * g) & MOST_POSITIVE;
            if (b == '0) b = g;
         end else begin
            g = $urandom_range(1, 65535);
            a = $urandom_range(0, 32767);
            b = $urandom_range(1, 32767);
            a = a * g;
            b = b * g;
         end
         offer_fraction(with_random_sign(a), with_random_sign(b));
      end
   endtask

   task automatic test_random_words(int count);
      logic signed [W-1:0] num;
      logic signed [W-1:0] den;
      repeat (count) begin
         num = $urandom();
         den = $urandom();
         case ($urandom_range(0, 9))
            0: den = '0;
            1: num = '0;
            2: num = MOST_NEGATIVE;
            3: den = MOST_NEGATIVE;
            default: ;
         endcase
         offer_fraction(num, den);
      end
   endtask

   task automatic test_small_values(int count);
      repeat (count)
         offer_fraction($signed($urandom_range(0, 128)) - 64,
                        $signed($urandom_range(0, 128)) - 64);
   endtask

   task automatic test_streaming(int bursts, int burst_len);
      repeat (bursts) begin
         idle_enable = 1'b0;
         test_common_factors(burst_len);
         idle_enable = 1'b1;
         test_random_words(burst_len);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_common_factors(600);
      test_random_words(500);
      test_small_values(200);
      test_streaming(5, 60);
      req_valid <= 1'b0;
      wait (reduced_fractions_due.size() == 0);
      repeat (16) @(posedge clock);
      $display("Reduced %0d fractions and checked %0d words, %0d with a zero denominator.",
               fractions_accepted, results_checked, zero_denominators_seen);
      $display("Mismatching fields: %0d.", mismatch_count);
      if (mismatch_count == 0 && reduced_fractions_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
